FILE: rtl/receive_range_reassembly_tracker_unit_assert.svh
// assertion macros for the range tracker checker
// no dependencies
`ifndef RECEIVE_RANGE_REASSEMBLY_TRACKER_UNIT_ASSERT_SVH
`define RECEIVE_RANGE_REASSEMBLY_TRACKER_UNIT_ASSERT_SVH

// implication that holds on every clocked cycle out of reset
`define RRT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("range tracker assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define RRT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("range tracker assertion failed");

`endif

FILE: rtl/rrt_pkg.sv
// shared constants, types and sequence compare functions for the range tracker
// no dependencies
package rrt_pkg;

  localparam int MAX_RANGES = 16;
  localparam int IDX_W = $clog2(MAX_RANGES);
  localparam int CNT_W = $clog2(MAX_RANGES + 2);
  localparam logic [30:0] WINDOW_RESET = 31'd1048576;

  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_CONSUME = 2'd1;
  localparam logic [1:0] OP_GAPS    = 2'd2;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic el_valid;
    logic flush;
  } merge_ctrl_t;

  function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic seq_le(input logic [31:0] a, input logic [31:0] b);
    return (a == b) || seq_lt(a, b);
  endfunction

  function automatic logic [30:0] sat_ready(input logic [31:0] s, input logic [31:0] e);
    logic [31:0] d;
    d = e - s;
    return d[31] ? 31'h7FFF_FFFF : d[30:0];
  endfunction

endpackage

FILE: rtl/rrt_cell.sv
// one range cell: holds start and end, shifts from its neighbor or loads
// depends on rrt_pkg
module rrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  rrt_pkg::cell_ctrl_t ctrl,
  input  logic [31:0]        nb_s,
  input  logic [31:0]        nb_e,
  input  logic [31:0]        ld_s,
  input  logic [31:0]        ld_e,
  output logic [31:0]        s,
  output logic [31:0]        e
);

  logic [31:0] s_r, s_nxt, e_r, e_nxt;

  always_comb begin
    s_nxt = s_r;
    e_nxt = e_r;
    if (ctrl.load) begin
      s_nxt = ld_s;
      e_nxt = ld_e;
    end else if (ctrl.shift) begin
      s_nxt = nb_s;
      e_nxt = nb_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
      e_r <= '0;
    end else begin
      s_r <= s_nxt;
      e_r <= e_nxt;
    end
  end

  assign s = s_r;
  assign e = e_r;

endmodule

FILE: rtl/rrt_merge.sv
// merge accumulator: folds a sorted stream of ranges, pushes merged ranges
// depends on rrt_pkg
module rrt_merge (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rrt_pkg::merge_ctrl_t      ctrl,
  input  logic [31:0]               el_s,
  input  logic [31:0]               el_e,
  output logic                      push_valid,
  output logic [31:0]               push_s,
  output logic [31:0]               push_e,
  output logic [rrt_pkg::CNT_W-1:0] count
);

  logic                      acc_v_r, acc_v_nxt;
  logic [31:0]               acc_s_r, acc_s_nxt, acc_e_r, acc_e_nxt;
  logic [rrt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    acc_v_nxt  = acc_v_r;
    acc_s_nxt  = acc_s_r;
    acc_e_nxt  = acc_e_r;
    cnt_nxt    = cnt_r;
    push_valid = 1'b0;
    if (ctrl.clear) begin
      acc_v_nxt = 1'b0;
      cnt_nxt   = '0;
    end else if (ctrl.flush) begin
      push_valid = acc_v_r;
      acc_v_nxt  = 1'b0;
    end else if (ctrl.el_valid) begin
      if (acc_v_r && rrt_pkg::seq_le(el_s, acc_e_r)) begin
        if (!rrt_pkg::seq_lt(el_e, acc_e_r)) acc_e_nxt = el_e;
      end else begin
        push_valid = acc_v_r;
        acc_v_nxt  = 1'b1;
        acc_s_nxt  = el_s;
        acc_e_nxt  = el_e;
        cnt_nxt    = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      acc_v_r <= acc_v_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_s_r <= acc_s_nxt;
    acc_e_r <= acc_e_nxt;
  end

  assign push_s = acc_s_r;
  assign push_e = acc_e_r;
  assign count  = cnt_r;

endmodule

FILE: rtl/receive_range_reassembly_tracker_unit.sv
// receive range reassembly tracker, top level; depends on rrt_pkg, rrt_cell, rrt_merge
// consume, unused op, out-of-window segment, report with no hole: straight to the result beat
// in-window segment: walk the ranges, flush, realign the ring, commit, then the result beat
// gap report: one hole beat per cycle while the output is not stalled, then realign;
// one item in flight, in_ready returns when it is done
// reset (synchronous, active low): one empty front range at 0, window 1048576
module receive_range_reassembly_tracker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_seg_seq,
  input  logic [15:0] in_seg_len,
  input  logic [30:0] in_consume_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_dropped_full,
  output logic        out_consume_error,
  output logic [31:0] out_ack_seq,
  output logic [30:0] out_ready_bytes,
  output logic [31:0] out_gap_start,
  output logic [31:0] out_gap_end,
  output logic        out_gap_valid,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata
);

  localparam int N = rrt_pkg::MAX_RANGES;
  localparam int CW = rrt_pkg::CNT_W;
  localparam logic [CW-1:0] MAXC = CW'(N);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_FLUSH  = 3'd2;
  localparam logic [2:0] S_ALIGN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_GAP    = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [30:0]   window_r;
  logic [CW-1:0] count_r, count_nxt;   // ranges in the table
  logic [CW-1:0] rot_r, rot_nxt;       // source ring rotations this item
  logic [CW-1:0] psh_r, psh_nxt;       // destination chain shifts this item
  logic          ins_r, ins_nxt;       // new range already streamed
  logic          is_data_r, is_data_nxt;
  logic [31:0]   first_r, first_nxt, send_r, send_nxt;
  logic          f_acc_r, f_acc_nxt, f_drop_r, f_drop_nxt, f_cerr_r, f_cerr_nxt;
  logic [31:0]   fs_r, fs_nxt, fe_r, fe_nxt;  // front range latched for gap beats

  // source ring and destination chain
  logic [31:0] src_s [N], src_e [N];
  logic [31:0] dst_s [N], dst_e [N];
  rrt_pkg::cell_ctrl_t src_ctrl [N];
  rrt_pkg::cell_ctrl_t dst_ctrl;
  logic src_rot, src_load, dst_shift;
  logic cons_load;
  logic [31:0] cons_s;

  // merge unit
  rrt_pkg::merge_ctrl_t mctrl;
  logic [31:0] el_s, el_e, push_s, push_e;
  logic        push_valid;
  logic [CW-1:0] mcount;

  // output register
  logic        ov_r, ov_nxt;
  logic        o_acc_r, o_acc_nxt, o_drop_r, o_drop_nxt, o_cerr_r, o_cerr_nxt;
  logic [31:0] o_ack_r, o_ack_nxt, o_gs_r, o_gs_nxt, o_ge_r, o_ge_nxt;
  logic [30:0] o_rdy_r, o_rdy_nxt;
  logic        o_gv_r, o_gv_nxt, o_last_r, o_last_nxt;
  logic        slot_free;

  logic        take_in;
  logic [31:0] seg_end, ready32, take32;

  assign slot_free = !ov_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign take_in   = in_valid && in_ready;
  assign seg_end   = in_seg_seq + 32'(in_seg_len);
  assign ready32   = src_e[0] - src_s[0];
  assign take32    = 32'(in_consume_bytes);

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_src
      logic [31:0] ld_s_w;
      logic [31:0] ld_e_w;
      assign src_ctrl[g].shift = src_rot;
      if (g == 0) begin : g_front
        // a consume moves only the front start, the end stays
        assign src_ctrl[g].load = src_load || cons_load;
        assign ld_s_w = cons_load ? cons_s : dst_s[g];
        assign ld_e_w = cons_load ? src_e[g] : dst_e[g];
      end else begin : g_rest
        assign src_ctrl[g].load = src_load;
        assign ld_s_w = dst_s[g];
        assign ld_e_w = dst_e[g];
      end
      rrt_cell u_src (
        .clk (clk), .rst_n (rst_n), .ctrl (src_ctrl[g]),
        .nb_s (src_s[(g + 1) % N]), .nb_e (src_e[(g + 1) % N]),
        .ld_s (ld_s_w), .ld_e (ld_e_w),
        .s (src_s[g]), .e (src_e[g])
      );
    end
    for (g = 0; g < N; g++) begin : g_dst
      // tail cell takes the merged range, the rest shift toward cell zero
      if (g == N - 1) begin : g_tail
        rrt_cell u_dst (
          .clk (clk), .rst_n (rst_n), .ctrl (dst_ctrl),
          .nb_s (push_s), .nb_e (push_e), .ld_s (32'd0), .ld_e (32'd0),
          .s (dst_s[g]), .e (dst_e[g])
        );
      end else begin : g_body
        rrt_cell u_dst (
          .clk (clk), .rst_n (rst_n), .ctrl (dst_ctrl),
          .nb_s (dst_s[g + 1]), .nb_e (dst_e[g + 1]), .ld_s (32'd0), .ld_e (32'd0),
          .s (dst_s[g]), .e (dst_e[g])
        );
      end
    end
  endgenerate

  assign dst_ctrl.load  = 1'b0;
  assign dst_ctrl.shift = dst_shift;

  rrt_merge u_merge (
    .clk (clk), .rst_n (rst_n), .ctrl (mctrl),
    .el_s (el_s), .el_e (el_e),
    .push_valid (push_valid), .push_s (push_s), .push_e (push_e),
    .count (mcount)
  );

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    rot_nxt     = rot_r;
    psh_nxt     = psh_r;
    ins_nxt     = ins_r;
    is_data_nxt = is_data_r;
    first_nxt   = first_r;
    send_nxt    = send_r;
    f_acc_nxt   = f_acc_r;
    f_drop_nxt  = f_drop_r;
    f_cerr_nxt  = f_cerr_r;
    fs_nxt      = fs_r;
    fe_nxt      = fe_r;
    src_rot     = 1'b0;
    src_load    = 1'b0;
    dst_shift   = 1'b0;
    cons_load   = 1'b0;
    cons_s      = src_s[0];
    mctrl       = '0;
    el_s        = src_s[0];
    el_e        = src_e[0];

    ov_nxt     = ov_r && !out_ready;
    o_acc_nxt  = o_acc_r;
    o_drop_nxt = o_drop_r;
    o_cerr_nxt = o_cerr_r;
    o_ack_nxt  = o_ack_r;
    o_rdy_nxt  = o_rdy_r;
    o_gs_nxt   = o_gs_r;
    o_ge_nxt   = o_ge_r;
    o_gv_nxt   = o_gv_r;
    o_last_nxt = o_last_r;

    case (state_r)
      S_IDLE: begin
        if (take_in) begin
          f_acc_nxt  = 1'b0;
          f_drop_nxt = 1'b0;
          f_cerr_nxt = 1'b0;
          rot_nxt    = '0;
          psh_nxt    = '0;
          ins_nxt    = 1'b0;
          fs_nxt     = src_s[0];
          fe_nxt     = src_e[0];
          is_data_nxt = 1'b0;
          state_nxt  = S_EMIT;
          case (in_opcode)
            rrt_pkg::OP_DATA: begin
              // window check against the front range before any walk
              if (rrt_pkg::seq_lt(src_e[0], seg_end) &&
                  rrt_pkg::seq_lt(seg_end, src_s[0] + 32'(window_r))) begin
                first_nxt   = rrt_pkg::seq_lt(src_e[0], in_seg_seq) ? in_seg_seq : src_e[0];
                send_nxt    = seg_end;
                is_data_nxt = 1'b1;
                mctrl.clear = 1'b1;
                state_nxt   = S_WALK;
              end
            end
            rrt_pkg::OP_CONSUME: begin
              // clamp to the ready bytes, flag the excess
              cons_load = 1'b1;
              if (take32 > ready32) begin
                cons_s     = src_s[0] + ready32;
                f_cerr_nxt = 1'b1;
              end else begin
                cons_s = src_s[0] + take32;
              end
            end
            rrt_pkg::OP_GAPS: begin
              if (count_r > CW'(1)) begin
                psh_nxt   = MAXC;
                state_nxt = S_GAP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        // stream one range per cycle into the merge unit, new range in order
        mctrl.el_valid = 1'b1;
        if (!ins_r && (rot_r == count_r || rrt_pkg::seq_le(first_r, src_s[0]))) begin
          el_s    = first_r;
          el_e    = send_r;
          ins_nxt = 1'b1;
        end else begin
          src_rot = 1'b1;
          rot_nxt = rot_r + 1'b1;
        end
        if (push_valid) begin
          dst_shift = 1'b1;
          psh_nxt   = psh_r + 1'b1;
        end
        if (ins_nxt && rot_nxt == count_r) state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        mctrl.flush = 1'b1;
        if (push_valid) begin
          dst_shift = 1'b1;
          psh_nxt   = psh_r + 1'b1;
        end
        state_nxt = S_ALIGN;
      end
      S_ALIGN: begin
        // finish one full turn of the ring; left-justify the new table
        if (rot_r < MAXC) begin
          src_rot = 1'b1;
          rot_nxt = rot_r + 1'b1;
        end
        if (psh_r < MAXC) begin
          dst_shift = 1'b1;
          psh_nxt   = psh_r + 1'b1;
        end
        if (rot_nxt >= MAXC && psh_nxt >= MAXC) begin
          state_nxt = is_data_r ? S_COMMIT : S_IDLE;
        end
      end
      S_COMMIT: begin
        if (mcount <= MAXC) begin
          src_load  = 1'b1;
          count_nxt = mcount;
          f_acc_nxt = 1'b1;
        end else begin
          f_drop_nxt = 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          o_acc_nxt  = f_acc_r;
          o_drop_nxt = f_drop_r;
          o_cerr_nxt = f_cerr_r;
          o_ack_nxt  = src_e[0];
          o_rdy_nxt  = rrt_pkg::sat_ready(src_s[0], src_e[0]);
          o_gs_nxt   = '0;
          o_ge_nxt   = '0;
          o_gv_nxt   = 1'b0;
          o_last_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_GAP: begin
        // one hole per beat from the two lowest cells, then rotate
        if (slot_free) begin
          ov_nxt     = 1'b1;
          o_acc_nxt  = 1'b0;
          o_drop_nxt = 1'b0;
          o_cerr_nxt = 1'b0;
          o_ack_nxt  = fe_r;
          o_rdy_nxt  = rrt_pkg::sat_ready(fs_r, fe_r);
          o_gs_nxt   = src_e[0];
          o_ge_nxt   = src_s[1];
          o_gv_nxt   = 1'b1;
          o_last_nxt = (rot_r + 2'd2 == count_r);
          src_rot    = 1'b1;
          rot_nxt    = rot_r + 1'b1;
          if (rot_r + 2'd2 == count_r) state_nxt = S_ALIGN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      window_r <= rrt_pkg::WINDOW_RESET;
      count_r  <= CW'(1);
      rot_r    <= '0;
      psh_r    <= '0;
      ins_r    <= 1'b0;
      is_data_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) window_r <= cfg_wdata;
      count_r  <= count_nxt;
      rot_r    <= rot_nxt;
      psh_r    <= psh_nxt;
      ins_r    <= ins_nxt;
      is_data_r <= is_data_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    send_r   <= send_nxt;
    f_acc_r  <= f_acc_nxt;
    f_drop_r <= f_drop_nxt;
    f_cerr_r <= f_cerr_nxt;
    fs_r     <= fs_nxt;
    fe_r     <= fe_nxt;
    o_acc_r  <= o_acc_nxt;
    o_drop_r <= o_drop_nxt;
    o_cerr_r <= o_cerr_nxt;
    o_ack_r  <= o_ack_nxt;
    o_rdy_r  <= o_rdy_nxt;
    o_gs_r   <= o_gs_nxt;
    o_ge_r   <= o_ge_nxt;
    o_gv_r   <= o_gv_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_valid         = ov_r;
  assign out_accepted      = o_acc_r;
  assign out_dropped_full  = o_drop_r;
  assign out_consume_error = o_cerr_r;
  assign out_ack_seq       = o_ack_r;
  assign out_ready_bytes   = o_rdy_r;
  assign out_gap_start     = o_gs_r;
  assign out_gap_end       = o_ge_r;
  assign out_gap_valid     = o_gv_r;
  assign out_last          = o_last_r;

endmodule

FILE: rtl/rrt_checker.sv
// port-level checker for the range tracker, bound to the top level
// depends on receive_range_reassembly_tracker_unit_assert.svh
`include "receive_range_reassembly_tracker_unit_assert.svh"

module rrt_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_accepted,
  input logic out_dropped_full,
  input logic out_consume_error,
  input logic out_gap_valid,
  input logic out_last
);

  // a result beat that is not a hole is always the only beat of its item
  `RRT_ASSERT_IMP(a_single_last, clk, rst_n, out_valid && !out_gap_valid, out_last)
  // a beat never carries more than one outcome flag
  `RRT_ASSERT_IMP(a_flags_excl, clk, rst_n, out_valid,
    !(out_accepted && out_dropped_full) && !(out_accepted && out_consume_error) &&
    !(out_dropped_full && out_consume_error))
  // hole beats carry no outcome flags
  `RRT_ASSERT_IMP(a_gap_clean, clk, rst_n, out_valid && out_gap_valid,
    !out_accepted && !out_dropped_full && !out_consume_error)
  // a stalled beat stays offered
  `RRT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

bind receive_range_reassembly_tracker_unit rrt_checker u_rrt_checker (
  .clk (clk), .rst_n (rst_n), .out_valid (out_valid), .out_ready (out_ready),
  .out_accepted (out_accepted), .out_dropped_full (out_dropped_full),
  .out_consume_error (out_consume_error), .out_gap_valid (out_gap_valid),
  .out_last (out_last)
);

FILE: dv/tb_receive_range_reassembly_tracker_unit.sv
// testbench for the receive range reassembly tracker: directed and random beats
// checked against an in-bench model of the range table
// depends on rrt_pkg and receive_range_reassembly_tracker_unit
`timescale 1ns / 1ps

module tb_receive_range_reassembly_tracker_unit;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NRANGE = rrt_pkg::MAX_RANGES;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEMS = 450;

  typedef struct packed {
    logic        accepted;
    logic        dropped_full;
    logic        consume_error;
    logic [31:0] ack_seq;
    logic [30:0] ready_bytes;
    logic [31:0] gap_start;
    logic [31:0] gap_end;
    logic        gap_valid;
    logic        last;
  } beat_t;

  // model of the range table plus the queue of beats still owed by the block
  class reassembly_scoreboard;
    logic [31:0] rng_lo[NRANGE];
    logic [31:0] rng_hi[NRANGE];
    int          n_ranges;
    logic [30:0] window;
    beat_t       owed[$];
    int          errors;

    function new();
      for (int i = 0; i < NRANGE; i++) begin
        rng_lo[i] = '0;
        rng_hi[i] = '0;
      end
      n_ranges = 1;
      window = rrt_pkg::WINDOW_RESET;
      errors = 0;
    endfunction

    function bit seq_before(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
    endfunction

    function logic [31:0] raw_ready();
      return rng_hi[0] - rng_lo[0];
    endfunction

    function logic [31:0] ack_now();
      return rng_hi[0];
    endfunction

    function void owe(logic acc, logic drop, logic cerr, logic [31:0] gs,
                      logic [31:0] ge, logic gv, logic lst);
      beat_t b;
      logic [31:0] d;
      d = raw_ready();
      b.accepted = acc;
      b.dropped_full = drop;
      b.consume_error = cerr;
      b.ack_seq = rng_hi[0];
      b.ready_bytes = d[31] ? 31'h7FFF_FFFF : d[30:0];
      b.gap_start = gs;
      b.gap_end = ge;
      b.gap_valid = gv;
      b.last = lst;
      owed = {owed, b};
    endfunction

    // 0 out of window, 1 recorded, 2 table full
    function int place_segment(logic [31:0] seq, logic [15:0] len);
      logic [31:0] ts[NRANGE+1], te[NRANGE+1], ns[NRANGE+1], ne[NRANGE+1];
      logic [31:0] seg_end, first;
      int pos, m, n;
      seg_end = seq + 32'(len);
      if (!(seq_before(rng_hi[0], seg_end) &&
            seq_before(seg_end, rng_lo[0] + 32'(window))))
        return 0;
      // the part already covered by the front range is not new
      first = seq_before(rng_hi[0], seq) ? seq : rng_hi[0];
      pos = n_ranges;
      for (int i = 0; i < n_ranges; i++) begin
        if (first == rng_lo[i] || seq_before(first, rng_lo[i])) begin
          pos = i;
          break;
        end
      end
      m = 0;
      for (int i = 0; i < n_ranges; i++) begin
        if (i == pos) begin
          ts[m] = first;
          te[m] = seg_end;
          m++;
        end
        ts[m] = rng_lo[i];
        te[m] = rng_hi[i];
        m++;
      end
      if (pos == n_ranges) begin
        ts[m] = first;
        te[m] = seg_end;
        m++;
      end
      // merge overlapping or touching neighbors
      n = 0;
      for (int i = 0; i < m; i++) begin
        if (n > 0 && (ts[i] == ne[n-1] || seq_before(ts[i], ne[n-1]))) begin
          if (!seq_before(te[i], ne[n-1])) ne[n-1] = te[i];
        end else begin
          ns[n] = ts[i];
          ne[n] = te[i];
          n++;
        end
      end
      if (n > NRANGE) return 2;
      for (int i = 0; i < n; i++) begin
        rng_lo[i] = ns[i];
        rng_hi[i] = ne[i];
      end
      n_ranges = n;
      return 1;
    endfunction

    function void note_item(logic [1:0] op, logic [31:0] seq, logic [15:0] len,
                            logic [30:0] take);
      int r;
      logic [31:0] rdy;
      case (op)
        rrt_pkg::OP_DATA: begin
          r = place_segment(seq, len);
          owe(r == 1, r == 2, 1'b0, '0, '0, 1'b0, 1'b1);
        end
        rrt_pkg::OP_CONSUME: begin
          rdy = raw_ready();
          if ({1'b0, take} > rdy) begin
            rng_lo[0] += rdy;
            owe(1'b0, 1'b0, 1'b1, '0, '0, 1'b0, 1'b1);
          end else begin
            rng_lo[0] += {1'b0, take};
            owe(1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
          end
        end
        rrt_pkg::OP_GAPS: begin
          if (n_ranges == 1) owe(1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
          for (int i = 1; i < n_ranges; i++)
            owe(1'b0, 1'b0, 1'b0, rng_hi[i-1], rng_lo[i], 1'b1, i == n_ranges - 1);
        end
        default: owe(1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_beat(beat_t got);
      beat_t w;
      if (owed.size() == 0) begin
        report("unexpected beat", '0, '0);
        return;
      end
      w = owed.pop_front();
      if (got.accepted !== w.accepted) report("accepted", got.accepted, w.accepted);
      if (got.dropped_full !== w.dropped_full)
        report("dropped_full", got.dropped_full, w.dropped_full);
      if (got.consume_error !== w.consume_error)
        report("consume_error", got.consume_error, w.consume_error);
      if (got.ack_seq !== w.ack_seq) report("ack_seq", got.ack_seq, w.ack_seq);
      if (got.ready_bytes !== w.ready_bytes)
        report("ready_bytes", got.ready_bytes, w.ready_bytes);
      if (got.gap_start !== w.gap_start) report("gap_start", got.gap_start, w.gap_start);
      if (got.gap_end !== w.gap_end) report("gap_end", got.gap_end, w.gap_end);
      if (got.gap_valid !== w.gap_valid) report("gap_valid", got.gap_valid, w.gap_valid);
      if (got.last !== w.last) report("last", got.last, w.last);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [31:0] in_seg_seq;
  logic [15:0] in_seg_len;
  logic [30:0] in_consume_bytes;
  logic        out_valid;
  logic        out_ready;
  logic        out_accepted;
  logic        out_dropped_full;
  logic        out_consume_error;
  logic [31:0] out_ack_seq;
  logic [30:0] out_ready_bytes;
  logic [31:0] out_gap_start;
  logic [31:0] out_gap_end;
  logic        out_gap_valid;
  logic        out_last;
  logic        cfg_we;
  logic [30:0] cfg_wdata;

  reassembly_scoreboard sb;
  bit quiet;        // phase with no idling on either side
  int stall_left;
  int idle_cycles;

  receive_range_reassembly_tracker_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_seg_seq       (in_seg_seq),
    .in_seg_len       (in_seg_len),
    .in_consume_bytes (in_consume_bytes),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_accepted     (out_accepted),
    .out_dropped_full (out_dropped_full),
    .out_consume_error(out_consume_error),
    .out_ack_seq      (out_ack_seq),
    .out_ready_bytes  (out_ready_bytes),
    .out_gap_start    (out_gap_start),
    .out_gap_end      (out_gap_end),
    .out_gap_valid    (out_gap_valid),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) stall_left <= pick_gap();
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_beat({out_accepted, out_dropped_full, out_consume_error, out_ack_seq,
                       out_ready_bytes, out_gap_start, out_gap_end, out_gap_valid,
                       out_last});
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // called either with valid low or in the step the previous beat was taken
  task automatic send(logic [1:0] op, logic [31:0] seq, logic [15:0] len,
                      logic [30:0] take);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_seg_seq <= seq;
    in_seg_len <= len;
    in_consume_bytes <= take;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, seq, len, take);
  endtask

  // drain everything owed, let the ring finish, then write the window
  task automatic set_window(logic [30:0] value);
    in_valid <= 1'b0;
    while (sb.owed.size() > 0) @(posedge clk);
    repeat (NRANGE + 8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.window = value;
  endtask

  task automatic random_item();
    int r;
    logic [31:0] rdy;
    logic [31:0] off;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      // well-formed segment near the front, sometimes straddling it
      case ($urandom_range(0, 3))
        0: off = 0;
        1: off = -$urandom_range(1, 200);
        default: off = $urandom_range(1, 4000);
      endcase
      len = ($urandom_range(0, 19) == 0) ? 16'(16'hFFFF - $urandom_range(0, 100))
                                         : 16'($urandom_range(0, 300));
      send(rrt_pkg::OP_DATA, sb.ack_now() + off, len, 31'($urandom));
    end else if (r < 60) begin
      send(rrt_pkg::OP_DATA, $urandom, 16'($urandom_range(0, 65535)), 31'($urandom));
    end else if (r < 78) begin
      rdy = sb.raw_ready();
      if ($urandom_range(0, 4) == 0 || rdy[31])
        send(rrt_pkg::OP_CONSUME, $urandom, 16'($urandom), 31'($urandom));
      else
        send(rrt_pkg::OP_CONSUME, $urandom, 16'($urandom), 31'($urandom_range(0, rdy)));
    end else if (r < 96) begin
      send(rrt_pkg::OP_GAPS, $urandom, 16'($urandom), 31'($urandom));
    end else begin
      send(OP_UNUSED, $urandom, 16'($urandom), 31'($urandom));
    end
  endtask

  initial begin
    logic [31:0] base;
    logic [30:0] windows[5];
    sb = new();
    quiet = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = rrt_pkg::OP_DATA;
    in_seg_seq = '0;
    in_seg_len = '0;
    in_consume_bytes = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, consumes, unused op, window edges
    send(rrt_pkg::OP_GAPS, 0, 0, 0);
    send(rrt_pkg::OP_CONSUME, 0, 0, 0);
    send(rrt_pkg::OP_CONSUME, 32'hFFFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF);
    send(OP_UNUSED, 0, 0, 0);
    send(rrt_pkg::OP_DATA, 0, 0, 0);                     // ends at the front end
    send(rrt_pkg::OP_DATA, 100, 50, 0);                  // leaves a hole
    send(rrt_pkg::OP_DATA, 0, 10, 0);
    send(rrt_pkg::OP_GAPS, 0, 0, 0);
    send(rrt_pkg::OP_DATA, 32'hFFFF_FFF0, 16'hFFFF, 0);  // starts behind the front, covers all
    send(rrt_pkg::OP_CONSUME, 0, 0, 5);
    send(rrt_pkg::OP_DATA, 32'h0010_0000, 16, 0);        // ends just past the window
    // fill the table, then one more disjoint segment and one that merges
    base = sb.ack_now();
    for (int i = 0; i < NRANGE - 1; i++) send(rrt_pkg::OP_DATA, base + 20 * (i + 1), 10, 0);
    send(rrt_pkg::OP_GAPS, 0, 0, 0);
    send(rrt_pkg::OP_DATA, base + 20 * NRANGE + 5, 3, 0);
    send(rrt_pkg::OP_DATA, base + 20 * NRANGE - 10, 10, 0);
    send(rrt_pkg::OP_GAPS, 0, 0, 0);

    // random phases across window settings, extremes included
    windows[0] = 31'd1;
    windows[1] = 31'h7FFF_FFFF;
    windows[2] = 31'd5000;
    windows[3] = 31'd65536;
    windows[4] = rrt_pkg::WINDOW_RESET;
    for (int p = 0; p < 5; p++) begin
      set_window(windows[p]);
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ITEMS / 5; k++) random_item();
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (sb.owed.size() > 0) @(posedge clk);
    repeat (NRANGE + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
